// ===== design/lagavg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lag-compensated average: shared package
// Widths, register codes, reset values, command bundle and sizing helpers.
// ----------------------------------------------------------------------------
package lagavg_pkg;

   localparam int PRICE_WIDTH_DEF = 32;
   localparam int EMA_EXTRA       = 8;
   localparam int GAIN_W          = 16;
   localparam int GAIN_FRAC       = 12;
   localparam int OUT_W           = 48;
   localparam int CHUNK_W         = 32;
   localparam int DIG_W           = 16;
   localparam int EMA_SHIFT       = 16;
   localparam int CORR_SHIFT      = GAIN_FRAC + EMA_EXTRA;

   // divide-by-three of an 18-bit partial value: q = (v * RECIP) >> SHIFT
   localparam int          DIV3_RECIP_W = 19;
   localparam logic [18:0] DIV3_RECIP   = 19'd349526;
   localparam int          DIV3_SHIFT   = 20;

   localparam int          CSR_IDX_W      = 2;
   localparam logic [1:0]  CSR_EMA_ALPHA  = 2'd0;
   localparam logic [1:0]  CSR_SLOPE_GAIN = 2'd1;
   localparam logic [1:0]  CSR_CURVE_GAIN = 2'd2;

   localparam logic [15:0] ALPHA_RESET = 16'd6554;
   localparam logic [15:0] SLOPE_RESET = 16'd4506;
   localparam logic [15:0] CURVE_RESET = 16'd614;

   typedef logic [1:0] lagavg_op_type;
   localparam lagavg_op_type OP_EMA   = 2'd0;
   localparam lagavg_op_type OP_SLOPE = 2'd1;
   localparam lagavg_op_type OP_CURVE = 2'd2;

   typedef struct packed {
      logic          clear;
      logic          sum_load;
      logic          div_step;
      logic          take_m;
      logic          seed;
      logic          mul_load;
      logic          mul_step;
      logic          mul_fin;
      logic          apply;
      logic          tay_init;
      logic          tay_sat;
      logic          fin_load;
      logic          commit;
      logic          commit_tay;
      logic          out_load;
      logic          out_ready;
      lagavg_op_type op;
   } lagavg_cmd_type;

   // 32-bit slices of the largest multiplier magnitude (second difference)
   function automatic int mul_chunks(input int pw);
      return (pw + EMA_EXTRA + 1 + CHUNK_W - 1) / CHUNK_W;
   endfunction

   // 16-bit digits of the divide-by-three dividend (price sum or final sum)
   function automatic int div_digits(input int pw);
      int src;
      src = (pw + 2 > OUT_W + 2) ? pw + 2 : OUT_W + 2;
      return (src + DIG_W - 1) / DIG_W;
   endfunction

endpackage
`default_nettype wire

// ===== design/lagavg_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lag-compensated average: controller
// Sequences divide, multiply and history steps for one bar at a time.
// ----------------------------------------------------------------------------
module lagavg_ctrl import lagavg_pkg::*; #(
   parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_restart,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output lagavg_cmd_type      cmd
);

   localparam int NC      = mul_chunks(PRICE_WIDTH);
   localparam int ND      = div_digits(PRICE_WIDTH);
   localparam int CNT_MAX = (ND > NC) ? ND : NC;
   localparam int CNT_W   = $clog2(CNT_MAX);

   localparam logic [2:0] BARS_FULL = 3'd4;
   localparam logic [2:0] BARS_TAY  = 3'd3;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DIV    = 4'd1;
   localparam logic [3:0] S_TAKE   = 4'd2;
   localparam logic [3:0] S_MLOAD  = 4'd3;
   localparam logic [3:0] S_MSTEP  = 4'd4;
   localparam logic [3:0] S_MFIN   = 4'd5;
   localparam logic [3:0] S_APPLY  = 4'd6;
   localparam logic [3:0] S_SAT    = 4'd7;
   localparam logic [3:0] S_FLOAD  = 4'd8;
   localparam logic [3:0] S_FDIV   = 4'd9;
   localparam logic [3:0] S_COMMIT = 4'd10;
   localparam logic [3:0] S_OUT    = 4'd11;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   lagavg_op_type    op_ff, op_in;
   logic [2:0]       count_ff, count_in;
   logic             ready_ff, ready_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       n_next;

   assign n_next    = (count_ff < BARS_FULL) ? count_ff + 3'd1 : BARS_FULL;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      count_in = count_ff;
      ready_in = ready_ff;
      cmd.op   = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_restart) begin
                  cmd.clear = 1'b1;
                  count_in  = '0;
                  ready_in  = 1'b0;
                  state_in  = S_OUT;
               end else begin
                  cmd.sum_load = 1'b1;
                  cnt_in       = '0;
                  state_in     = S_DIV;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ND - 1)) begin
               state_in = S_TAKE;
            end
         end
         S_TAKE: begin
            cmd.take_m = 1'b1;
            if (count_ff == '0) begin
               cmd.seed = 1'b1;
               state_in = S_COMMIT;
            end else begin
               op_in    = OP_EMA;
               state_in = S_MLOAD;
            end
         end
         S_MLOAD: begin
            cmd.mul_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_MSTEP;
         end
         S_MSTEP: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NC - 1)) begin
               state_in = S_MFIN;
            end
         end
         S_MFIN: begin
            cmd.mul_fin = 1'b1;
            state_in    = S_APPLY;
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            unique case (op_ff)
               OP_EMA: begin
                  if (n_next >= BARS_TAY) begin
                     cmd.tay_init = 1'b1;
                     op_in        = OP_SLOPE;
                     state_in     = S_MLOAD;
                  end else begin
                     state_in = S_COMMIT;
                  end
               end
               OP_SLOPE: begin
                  op_in    = OP_CURVE;
                  state_in = S_MLOAD;
               end
               default: begin
                  state_in = S_SAT;
               end
            endcase
         end
         S_SAT: begin
            cmd.tay_sat = 1'b1;
            state_in    = (n_next == BARS_FULL) ? S_FLOAD : S_COMMIT;
         end
         S_FLOAD: begin
            cmd.fin_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_FDIV;
         end
         S_FDIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ND - 1)) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit     = 1'b1;
            cmd.commit_tay = (n_next >= BARS_TAY);
            count_in       = n_next;
            ready_in       = (n_next == BARS_FULL);
            state_in       = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load  = 1'b1;
               cmd.out_ready = ready_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         op_ff        <= OP_EMA;
         count_ff     <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         op_ff        <= op_in;
         count_ff     <= count_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= BARS_FULL)
      else $error("bar count beyond four");

   a_sat_after_curve: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SAT |-> op_ff == OP_CURVE)
      else $error("saturation reached before the curve term");

   a_final_needs_history: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FLOAD |-> count_ff >= BARS_TAY)
      else $error("final average started with fewer than three bars");

   a_restart_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_restart) |=>
         (state_ff == S_OUT && !ready_ff && count_ff == '0))
      else $error("restart did not clear history");

endmodule
`default_nettype wire

// ===== design/lagavg_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lag-compensated average: datapath
// Divide-by-three unit, shared 16x32 multiplier, history and result registers.
// ----------------------------------------------------------------------------
module lagavg_dp import lagavg_pkg::*; #(
   parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lagavg_cmd_type         cmd,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [GAIN_W-1:0]      csr_write_data,
   input  wire logic [PRICE_WIDTH-1:0] req_high_price,
   input  wire logic [PRICE_WIDTH-1:0] req_low_price,
   input  wire logic [PRICE_WIDTH-1:0] req_close_price,
   output logic [OUT_W-1:0]            rsp_average_value,
   output logic                        rsp_ready_res
);

   localparam int PW     = PRICE_WIDTH;
   localparam int EW     = PW + EMA_EXTRA;
   localparam int DW     = EW + 2;
   localparam int MAG_W  = EW + 1;
   localparam int NC     = mul_chunks(PW);
   localparam int MPAD   = NC * CHUNK_W;
   localparam int ACC_W  = MPAD + GAIN_W;
   localparam int CORR_W = ACC_W - CORR_SHIFT;
   localparam int ND     = div_digits(PW);
   localparam int DIV_W  = ND * DIG_W;
   localparam int TW     = (MPAD - 1 > OUT_W + 1) ? MPAD - 1 : OUT_W + 1;
   localparam int FW     = OUT_W + 2;
   localparam int V_W    = DIG_W + 2;
   localparam int PROD_W = CHUNK_W + GAIN_W;

   // configuration
   logic [GAIN_W-1:0] alpha_ff, slope_ff, curve_ff;

   // history
   logic [PW-1:0]    h0_ff, h1_ff;
   logic [EW-1:0]    ema_ff, eh0_ff;
   logic [OUT_W-1:0] prev_corr_ff;

   // working registers
   logic [DIV_W-1:0]  div_ff, quo_ff;
   logic [1:0]        rem_ff;
   logic [PW-1:0]     m_ff;
   logic [EW-1:0]     prev_ema_ff;
   logic [MPAD-1:0]   mag_ff;
   logic              msign_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [TW-1:0]     tay_acc_ff;
   logic [OUT_W-1:0]  tay_ff;
   logic              fsign_ff;
   logic [OUT_W-1:0]  rsp_value_ff;
   logic              rsp_ready_ff;

   // ---- divide by three, one 16-bit digit per cycle, MSB first ----
   logic [PW+1:0]                 price_sum;
   logic [V_W-1:0]                div_v;
   logic [V_W+DIV3_RECIP_W-1:0]   div_prod;
   logic [DIG_W-1:0]              div_q;
   logic [V_W-1:0]                div_rem_full;

   assign price_sum = {2'b00, req_high_price} + {2'b00, req_low_price}
                    + {2'b00, req_close_price};
   assign div_v        = {rem_ff, div_ff[DIV_W-1 -: DIG_W]};
   assign div_prod     = div_v * DIV3_RECIP;
   assign div_q        = div_prod[DIV3_SHIFT +: DIG_W];
   assign div_rem_full = div_v - ({1'b0, div_q, 1'b0} + {2'b00, div_q});

   // ---- multiplier operand: signed difference and its magnitude ----
   logic [DW-1:0]     m_ext, ema_ext, prev_ext, eh_ext;
   logic [DW-1:0]     d_pos, d_neg;
   logic [MAG_W-1:0]  d_mag;
   logic [GAIN_W-1:0] gain_sel;

   assign m_ext    = {2'b00, m_ff, {EMA_EXTRA{1'b0}}};
   assign ema_ext  = {2'b00, ema_ff};
   assign prev_ext = {2'b00, prev_ema_ff};
   assign eh_ext   = {2'b00, eh0_ff};

   always_comb begin
      unique case (cmd.op)
         OP_EMA: begin
            d_pos    = m_ext - ema_ext;
            d_neg    = ema_ext - m_ext;
            gain_sel = alpha_ff;
         end
         OP_SLOPE: begin
            d_pos    = ema_ext - prev_ext;
            d_neg    = prev_ext - ema_ext;
            gain_sel = slope_ff;
         end
         default: begin
            d_pos    = ema_ext + eh_ext - {prev_ext[DW-2:0], 1'b0};
            d_neg    = {prev_ext[DW-2:0], 1'b0} - ema_ext - eh_ext;
            gain_sel = curve_ff;
         end
      endcase
   end

   assign d_mag = d_pos[DW-1] ? d_neg[MAG_W-1:0] : d_pos[MAG_W-1:0];

   // ---- shared multiplier: 32-bit slice per cycle, accumulate MSB first ----
   logic [PROD_W-1:0] prod_next;
   logic [ACC_W-1:0]  acc_next;

   assign prod_next = mag_ff[MPAD-1 -: CHUNK_W] * gain_ff;
   assign acc_next  = (acc_ff << CHUNK_W) + ACC_W'(prod_ff);

   // ---- applying a product ----
   logic [EW-1:0]     ema_q, ema_upd;
   logic [CORR_W-1:0] corr_q;
   logic [TW-1:0]     tay_upd;
   logic [PW+2:0]     wma_sum;

   assign ema_q   = acc_ff[EMA_SHIFT +: EW];
   assign ema_upd = msign_ff ? ema_ff - ema_q : ema_ff + ema_q;
   assign corr_q  = acc_ff[ACC_W-1:CORR_SHIFT];
   assign tay_upd = msign_ff ? tay_acc_ff - TW'(corr_q) : tay_acc_ff + TW'(corr_q);
   assign wma_sum = {1'b0, m_ff, 2'b00} + {2'b00, h0_ff, 1'b0}
                  + {3'b000, h0_ff} + {3'b000, h1_ff};

   // ---- saturation to the signed output range ----
   logic [TW-OUT_W:0] tay_hi;
   logic [OUT_W-1:0]  tay_sat_val;

   assign tay_hi = tay_acc_ff[TW-1:OUT_W-1];

   always_comb begin
      if (!tay_acc_ff[TW-1] && (|tay_hi)) begin
         tay_sat_val = {1'b0, {(OUT_W-1){1'b1}}};
      end else if (tay_acc_ff[TW-1] && !(&tay_hi)) begin
         tay_sat_val = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         tay_sat_val = tay_acc_ff[OUT_W-1:0];
      end
   end

   // ---- final 4-2 average: (2*T0 + T1) / 3 toward zero ----
   logic [FW-1:0]    fin_t2, fin_p, fin_pos, fin_neg, fin_mag;
   logic [OUT_W-1:0] fin_q, fin_val;

   assign fin_t2  = {tay_ff[OUT_W-1], tay_ff, 1'b0};
   assign fin_p   = {{2{prev_corr_ff[OUT_W-1]}}, prev_corr_ff};
   assign fin_pos = fin_t2 + fin_p;
   assign fin_neg = '0 - fin_t2 - fin_p;
   assign fin_mag = fin_pos[FW-1] ? fin_neg : fin_pos;
   assign fin_q   = quo_ff[OUT_W-1:0];
   assign fin_val = fsign_ff ? '0 - fin_q : fin_q;

   // configuration and history
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= ALPHA_RESET;
         slope_ff     <= SLOPE_RESET;
         curve_ff     <= CURVE_RESET;
         h0_ff        <= '0;
         h1_ff        <= '0;
         ema_ff       <= '0;
         eh0_ff       <= '0;
         prev_corr_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_EMA_ALPHA:  alpha_ff <= csr_write_data;
               CSR_SLOPE_GAIN: slope_ff <= csr_write_data;
               CSR_CURVE_GAIN: curve_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
         if (cmd.clear) begin
            h0_ff        <= '0;
            h1_ff        <= '0;
            ema_ff       <= '0;
            eh0_ff       <= '0;
            prev_corr_ff <= '0;
         end else begin
            if (cmd.take_m && cmd.seed) begin
               ema_ff <= {quo_ff[PW-1:0], {EMA_EXTRA{1'b0}}};
            end else if (cmd.apply && cmd.op == OP_EMA) begin
               ema_ff <= ema_upd;
            end
            if (cmd.commit) begin
               h1_ff  <= h0_ff;
               h0_ff  <= m_ff;
               eh0_ff <= prev_ema_ff;
               if (cmd.commit_tay) begin
                  prev_corr_ff <= tay_ff;
               end
            end
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.sum_load) begin
         div_ff <= DIV_W'(price_sum);
         rem_ff <= '0;
      end else if (cmd.fin_load) begin
         div_ff   <= DIV_W'(fin_mag);
         rem_ff   <= '0;
         fsign_ff <= fin_pos[FW-1];
      end else if (cmd.div_step) begin
         div_ff <= {div_ff[DIV_W-DIG_W-1:0], {DIG_W{1'b0}}};
         rem_ff <= div_rem_full[1:0];
         quo_ff <= {quo_ff[DIV_W-DIG_W-1:0], div_q};
      end

      if (cmd.take_m) begin
         m_ff        <= quo_ff[PW-1:0];
         prev_ema_ff <= ema_ff;
      end

      if (cmd.mul_load) begin
         mag_ff   <= MPAD'(d_mag);
         msign_ff <= d_pos[DW-1];
         gain_ff  <= gain_sel;
         prod_ff  <= '0;
         acc_ff   <= '0;
      end else if (cmd.mul_step) begin
         mag_ff  <= mag_ff << CHUNK_W;
         prod_ff <= prod_next;
         acc_ff  <= acc_next;
      end else if (cmd.mul_fin) begin
         acc_ff <= acc_next;
      end

      if (cmd.tay_init) begin
         tay_acc_ff <= TW'(wma_sum[PW+2:3]);
      end else if (cmd.apply && cmd.op != OP_EMA) begin
         tay_acc_ff <= tay_upd;
      end

      if (cmd.tay_sat) begin
         tay_ff <= tay_sat_val;
      end

      if (cmd.out_load) begin
         rsp_value_ff <= cmd.out_ready ? fin_val : '0;
         rsp_ready_ff <= cmd.out_ready;
      end
   end

   assign rsp_average_value = rsp_value_ff;
   assign rsp_ready_res     = rsp_ready_ff;

   a_rem_below_three: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff != 2'd3)
      else $error("divide-by-three remainder out of range");

endmodule
`default_nettype wire

// ===== design/one_bar_lag_moving_average.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// One-bar-lag moving average
// Typical price, exponential average and a lag-compensated weighted average.
// ----------------------------------------------------------------------------
// Throughput: one bar at a time. A full bar (fourth onwards) runs the divider on 16-bit
//   digits, three products through the 16x32 multiplier in 32-bit slices and the final
//   divide; bars one to three take shorter paths, and a restart only clears history and
//   returns a result that is not ready. Reset: synchronous; clears history.
// ----------------------------------------------------------------------------
module one_bar_lag_moving_average import lagavg_pkg::*; #(
   parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   // bar input
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [PRICE_WIDTH-1:0] req_high_price,
   input  wire logic [PRICE_WIDTH-1:0] req_low_price,
   input  wire logic [PRICE_WIDTH-1:0] req_close_price,
   input  wire logic                   req_restart,

   // result output
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [OUT_W-1:0]            rsp_average_value,
   output logic                        rsp_ready_res,

   // configuration writes
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [GAIN_W-1:0]      csr_write_data
);

   // Command bundle from the sequencer to the datapath. Each cycle the
   // controller raises the steps to perform: digit steps of the divider,
   // slices of the shared multiplier, application of a product to the
   // exponential average or to the weighted sum, and the history update.
   lagavg_cmd_type cmd;

   // Controller: holds the bar count (saturating at four), the step
   // counter, the operand select and the result-valid flag. It accepts a
   // transaction only from idle, but does so while the previous result is
   // still waiting in the output register; it only waits before loading
   // that register again.
   lagavg_ctrl #(
      .PRICE_WIDTH (PRICE_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd)
   );

   // Datapath: the typical price is the price sum divided by three, one
   // 16-bit digit per cycle; the same unit later forms the final
   // (2*T0 + T1)/3. Every gain product goes through one 16x32 multiplier,
   // accumulated slice by slice, with the magnitude taken beforehand so
   // the shifted product truncates toward zero. The configuration
   // registers sit here too, written straight from the port.
   lagavg_dp #(
      .PRICE_WIDTH (PRICE_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_high_price    (req_high_price),
      .req_low_price     (req_low_price),
      .req_close_price   (req_close_price),
      .rsp_average_value (rsp_average_value),
      .rsp_ready_res     (rsp_ready_res)
   );

endmodule
`default_nettype wire

// ===== tb/one_bar_lag_moving_average_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One-bar-lag moving average: self-checking testbench
// Drives price bars with random idling on both channels, predicts each
// result in a scoreboard that tracks the average's history and settings,
// and compares every accepted result field by field, oldest first.
// ----------------------------------------------------------------------------
module one_bar_lag_moving_average_tb import lagavg_pkg::*;;

   localparam int          BAR_W         = PRICE_WIDTH_DEF;
   localparam int          CYCLE_LIMIT   = 500000;
   // allow headroom on top of the time a full bar takes through the block
   localparam int          SETTLE_CYCLES = 40;
   localparam int          ITEMS_PER_SET = 160;
   // index 3 maps to no register; a write there must leave the others alone
   localparam logic [1:0]  CSR_UNUSED    = 2'd3;
   localparam longint      AVG_MAX       = (longint'(1) <<< (OUT_W - 1)) - 1;
   localparam longint      AVG_MIN       = -AVG_MAX - 1;

   // -------------------------------------------------------------------------
   // Scoreboard: mirrors the block's history and settings, predicts one
   // result per accepted bar and checks results in order of arrival.
   // -------------------------------------------------------------------------
   class lag_average_scoreboard;
      typedef struct packed {
         logic [OUT_W-1:0] average;
         logic             ready;
      } average_result_type;

      logic [GAIN_W-1:0]  alpha, slope, curve;
      logic [BAR_W-1:0]   typical_prev [2];
      longint             ema_now;
      longint             ema_prev [2];
      longint             last_trend;
      int unsigned        bars_seen;
      average_result_type expected_results [$];
      int unsigned        fail_count;

      function new();
         alpha      = ALPHA_RESET;
         slope      = SLOPE_RESET;
         curve      = CURVE_RESET;
         fail_count = 0;
         clear_history();
      endfunction

      function void clear_history();
         typical_prev[0] = '0;
         typical_prev[1] = '0;
         ema_now         = 0;
         ema_prev[0]     = 0;
         ema_prev[1]     = 0;
         last_trend      = 0;
         bars_seen       = 0;
      endfunction

      // append a prediction at the tail, behind every outstanding one
      function void queue_result(average_result_type r);
         expected_results.insert(expected_results.size(), r);
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
         case (idx)
            CSR_EMA_ALPHA:  alpha = data;
            CSR_SLOPE_GAIN: slope = data;
            CSR_CURVE_GAIN: curve = data;
            default: ;
         endcase
      endfunction

      // trunc(g * v / 2^shift), sign taken from v, magnitude split to stay in 64 bits
      function longint gain_product(logic [GAIN_W-1:0] g, longint v, int shift);
         logic [63:0] mag;
         logic [63:0] q;
         mag = (v < 0) ? 64'(-v) : 64'(v);
         q   = (mag >> 16) * 64'(g) + (((mag & 64'hFFFF) * 64'(g)) >> 16);
         q   = q >> (shift - 16);
         return (v < 0) ? -longint'(q) : longint'(q);
      endfunction

      function longint clamp_average(longint v);
         if (v > AVG_MAX) return AVG_MAX;
         if (v < AVG_MIN) return AVG_MIN;
         return v;
      endfunction

      function void note_bar(logic [BAR_W-1:0] high, logic [BAR_W-1:0] low,
                             logic [BAR_W-1:0] close, logic restart);
         logic [63:0]        typical;
         longint             ema_before, diff, wma, d1, d2, corr, trend, smoothed;
         int unsigned        n;
         average_result_type r;
         r = '0;
         if (restart) begin
            clear_history();
            queue_result(r);
            return;
         end
         typical    = (64'(high) + 64'(low) + 64'(close)) / 3;
         ema_before = ema_now;
         // seed the average with the first typical price, then smooth
         if (bars_seen == 0) begin
            ema_now = longint'(typical << EMA_EXTRA);
         end else begin
            diff    = longint'(typical << EMA_EXTRA) - ema_now;
            ema_now = ema_now + gain_product(alpha, diff, EMA_SHIFT);
         end
         n = (bars_seen < 4) ? bars_seen + 1 : 4;
         if (n >= 3) begin
            wma   = longint'((64'd4 * typical + 64'd3 * 64'(typical_prev[0])
                              + 64'(typical_prev[1])) >> 3);
            d1    = ema_now - ema_before;
            d2    = ema_now - 2 * ema_before + ema_prev[0];
            corr  = gain_product(slope, d1, CORR_SHIFT)
                  + gain_product(curve, d2, CORR_SHIFT);
            trend = clamp_average(wma + corr);
            if (n >= 4) begin
               smoothed  = clamp_average((4 * trend + 2 * last_trend) / 6);
               r.average = smoothed[OUT_W-1:0];
               r.ready   = 1'b1;
            end
            last_trend = trend;
         end
         typical_prev[1] = typical_prev[0];
         typical_prev[0] = typical[BAR_W-1:0];
         ema_prev[1]     = ema_prev[0];
         ema_prev[0]     = ema_before;
         bars_seen       = n;
         queue_result(r);
      endfunction

      function void check_result(logic [OUT_W-1:0] average, logic ready);
         average_result_type want;
         if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("[%0t] result with nothing outstanding: average %0d ready %0b",
                        $realtime, $signed(average), ready);
            return;
         end
         want = expected_results.pop_front();
         if (average !== want.average || ready !== want.ready) begin
            fail_count++;
            if (fail_count <= 10) begin
               if (average !== want.average)
                  $display("[%0t] average_value mismatch: expected %0d, got %0d",
                           $realtime, $signed(want.average), $signed(average));
               if (ready !== want.ready)
                  $display("[%0t] ready_res mismatch: expected %0b, got %0b",
                           $realtime, want.ready, ready);
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals
   // -------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   logic [BAR_W-1:0]      req_high_price  = '0;
   logic [BAR_W-1:0]      req_low_price   = '0;
   logic [BAR_W-1:0]      req_close_price = '0;
   logic                  req_restart     = 1'b0;

   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   logic [OUT_W-1:0]      rsp_average_value;
   logic                  rsp_ready_res;

   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [GAIN_W-1:0]     csr_write_data   = '0;

   lag_average_scoreboard board;
   bit                    steady   = 1'b0;   // no idling on either side
   int unsigned           hold_off = 0;      // receiver hold-off, in cycles
   int unsigned           cycle_count = 0;
   logic [BAR_W-1:0]      walk_level = 32'h0064_0000;

   one_bar_lag_moving_average #(.PRICE_WIDTH(BAR_W)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_high_price    (req_high_price),
      .req_low_price     (req_low_price),
      .req_close_price   (req_close_price),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_average_value (rsp_average_value),
      .rsp_ready_res     (rsp_ready_res),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin : clock_gen
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Bar driver
   // -------------------------------------------------------------------------

   // Offer one bar, idling first at random; keep valid high on return so a
   // following transaction can go out back to back.
   task automatic send_bar(input logic [BAR_W-1:0] high, input logic [BAR_W-1:0] low,
                           input logic [BAR_W-1:0] close, input logic restart);
      while (!steady && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_high_price  <= high;
      req_low_price   <= low;
      req_close_price <= close;
      req_restart     <= restart;
      // stall is sampled before the edge updates it, so this is the handshake
      do @(posedge clock); while (req_stall);
      board.note_bar(high, low, close, restart);
   endtask

   // Drop valid and wait until every outstanding result has come back, then
   // give the block time to finish its bookkeeping.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [GAIN_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      board.set_register(idx, data);
   endtask

   // Write all three registers plus a stray write to the unused index; only
   // called with the block idle.
   task automatic apply_settings(input logic [GAIN_W-1:0] alpha,
                                 input logic [GAIN_W-1:0] slope,
                                 input logic [GAIN_W-1:0] curve);
      write_register(CSR_EMA_ALPHA, alpha);
      write_register(CSR_SLOPE_GAIN, slope);
      write_register(CSR_CURVE_GAIN, curve);
      write_register(CSR_UNUSED, GAIN_W'($urandom));
      csr_write_enable <= 1'b0;
   endtask

   // Price source: mostly a random walk around a moving level, with some
   // fully random and some extreme values mixed in.
   function automatic logic [BAR_W-1:0] pick_price(input int unsigned style,
                                                    input logic [BAR_W-1:0] level);
      logic [BAR_W-1:0] offset;
      offset = BAR_W'($urandom_range(20'hFFFFF));
      case (style)
         0:       return BAR_W'($urandom);
         1:       return $urandom_range(1) ? '1 : '0;
         default: return level + offset - BAR_W'(20'h80000);
      endcase
   endfunction

   task automatic run_random_bars(input int unsigned count, input int unsigned hold_at);
      int unsigned i;
      int unsigned roll;
      int unsigned style;
      for (i = 0; i < count; i++) begin
         // long receiver hold-off while bars keep coming: the block backs up
         if (i == hold_at) hold_off = 400;
         // drift the walk, occasionally jump it somewhere new
         if ($urandom_range(99) < 3) walk_level = BAR_W'($urandom);
         else walk_level = walk_level + BAR_W'($urandom_range(22'h3FFFFF)) - BAR_W'(22'h200000);
         roll  = $urandom_range(99);
         style = (roll < 70) ? 2 : (roll < 90) ? 0 : 1;
         send_bar(pick_price(style, walk_level), pick_price(style, walk_level),
                  pick_price(style, walk_level), $urandom_range(99) < 4);
      end
   endtask

   // -------------------------------------------------------------------------
   // Result sink: check accepted transactions, then choose the next stall
   // -------------------------------------------------------------------------
   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_result(rsp_average_value, rsp_ready_res);
         if (hold_off > 0) begin
            rsp_stall <= 1'b1;
            hold_off--;
         end else if (steady) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 24);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed bars at the reset settings
      send_bar('1, '1, '1, 1'b1);                       // restart, prices ignored
      send_bar('0, '0, '0, 1'b0);                       // first bar seeds the average
      send_bar('1, '1, '1, 1'b0);                       // price sum overflows 32 bits
      send_bar('1, '1, '1, 1'b0);                       // third bar: first trend value
      send_bar('0, '0, '0, 1'b0);                       // fourth bar: ready, sharp drop
      send_bar('1, '1, '1, 1'b0);
      send_bar('0, '1, '0, 1'b0);
      send_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000, 1'b0);
      send_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 1'b0);
      send_bar('0, '0, '0, 1'b1);                       // restart mid-stream
      send_bar(32'd1, 32'd1, 32'd1, 1'b0);
      send_bar(32'd2, 32'd2, 32'd2, 1'b0);
      send_bar('0, '0, '0, 1'b1);                       // restart after two bars
      send_bar(32'h0064_0000, 32'h0063_0000, 32'h0063_8000, 1'b0);
      send_bar(32'h0065_0000, 32'h0064_0000, 32'h0064_C000, 1'b0);
      send_bar(32'h0066_0000, 32'h0065_0000, 32'h0065_8000, 1'b0);
      send_bar(32'h0067_0000, 32'h0066_0000, 32'h0066_4000, 1'b0);
      send_bar(32'h0064_0000, 32'h0060_0000, 32'h0061_0000, 1'b0);
      send_bar(32'h0050_0000, 32'h0040_0000, 32'h0041_0000, 1'b0);
      send_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 1'b0);
      drain_results();

      // Minimum settings: average frozen at its seed, no correction
      apply_settings('0, '0, '0);
      send_bar('0, '0, '0, 1'b1);
      run_random_bars(ITEMS_PER_SET, ITEMS_PER_SET);
      drain_results();

      // Maximum settings
      apply_settings('1, '1, '1);
      send_bar('0, '0, '0, 1'b1);
      run_random_bars(ITEMS_PER_SET, ITEMS_PER_SET);
      drain_results();

      // Reset settings back, with a long stretch free of idling
      apply_settings(ALPHA_RESET, SLOPE_RESET, CURVE_RESET);
      steady = 1'b1;
      run_random_bars(ITEMS_PER_SET / 2, ITEMS_PER_SET);
      steady = 1'b0;
      run_random_bars(ITEMS_PER_SET / 2, ITEMS_PER_SET);
      drain_results();

      // Random settings; the receiver backs off for a long stretch mid-run
      apply_settings(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom));
      run_random_bars(ITEMS_PER_SET, 20);
      drain_results();

      apply_settings(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom));
      run_random_bars(ITEMS_PER_SET, ITEMS_PER_SET);
      drain_results();

      if (board.fail_count == 0 && board.expected_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
